>>> design/chacha_pkg.sv
package chacha_pkg;

    // Widths of the word fields
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int POS_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // Block function
    localparam int STATE_WORDS = 16;
    localparam int DROUNDS     = 10;
    localparam int DR_W        = $clog2(DROUNDS);

    // Queue between front and back (power of two depth)
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    // "expand 32-byte k"
    localparam logic [3:0][WORD_W-1:0] SIGMA = {
        32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
    };

    typedef logic [STATE_WORDS-1:0][WORD_W-1:0] t_ks_block;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY01    = 3'd0,
        CFG_KEY23    = 3'd1,
        CFG_KEY45    = 3'd2,
        CFG_KEY67    = 3'd3,
        CFG_NONCE01  = 3'd4,
        CFG_NONCE2   = 3'd5,
        CFG_INIT_CTR = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0][WORD_W-1:0] key;
        logic [2:0][WORD_W-1:0] nonce;
        logic [WORD_W-1:0]      init_ctr;
    } t_cfg;

    // One classified word from the front
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic              new_blk;
        logic [WORD_W-1:0] ctr;
    } t_job;

    // Block generation request
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] ctr;
    } t_blk_req;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_GEN,
        BK_EMIT
    } t_back_st;

    typedef enum logic [1:0] {
        BL_IDLE,
        BL_ROUND,
        BL_FINAL
    } t_blk_st;

endpackage

>>> design/chacha_if.sv
// Input word channel
interface chacha_in_if import chacha_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              message_start;

    modport source (output valid, output data_byte, output message_start, input ready);
    modport sink   (input valid, input data_byte, input message_start, output ready);
endinterface

// Result word channel
interface chacha_out_if import chacha_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] result_byte;

    modport source (output valid, output result_byte, input ready);
    modport sink   (input valid, input result_byte, output ready);
endinterface

// Configuration write channel
interface chacha_cfg_if import chacha_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/chacha_front.sv
module chacha_front import chacha_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    chacha_in_if.sink         i_data,
    input  logic [WORD_W-1:0] i_init_ctr,
    input  logic              i_full,
    output logic              o_push,
    output t_job              o_job
);

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [WORD_W-1:0] r_ctr, n_ctr;
    logic [POS_W-1:0]  pos_eff;
    logic [WORD_W-1:0] ctr_eff;

    assign i_data.ready = !i_full;
    assign o_push       = i_data.valid && !i_full;

    // Message start restarts position and counter before this byte
    assign pos_eff = i_data.message_start ? '0 : r_pos;
    assign ctr_eff = i_data.message_start ? i_init_ctr : r_ctr;

    always_comb begin
        o_job.data    = i_data.data_byte;
        o_job.pos     = pos_eff;
        o_job.new_blk = (pos_eff == '0);
        o_job.ctr     = ctr_eff;
    end

    // Counter advances once per block, position wraps at 64
    always_comb begin
        n_pos = r_pos;
        n_ctr = r_ctr;
        if (o_push) begin
            n_pos = pos_eff + POS_W'(1);
            n_ctr = (pos_eff == '0) ? ctr_eff + WORD_W'(1) : ctr_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ctr <= '0;
        end else begin
            r_pos <= n_pos;
            r_ctr <= n_ctr;
        end
    end

endmodule

>>> design/chacha_fifo.sv
module chacha_fifo import chacha_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_wdata,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_rdata
);

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_CW-1:0] r_cnt;

    assign o_full  = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rp];

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + FIFO_CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - FIFO_CW'(1);
            end
        end
    end

endmodule

>>> design/chacha_block.sv
module chacha_block import chacha_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_blk_req  i_req,
    input  t_cfg      i_cfg,
    output logic      o_done,
    output t_ks_block o_ks
);

    t_blk_st           r_st, n_st;
    t_ks_block         r_work, n_work;
    t_ks_block         r_ks;
    t_ks_block         init_cur, ff_sum;
    logic [WORD_W-1:0] r_ctr;
    logic [1:0]        r_step;
    logic              r_diag;
    logic [DR_W-1:0]   r_dround;
    logic              r_done;
    logic              ld_init, do_round, do_final, last_step;

    function automatic t_ks_block make_init(input t_cfg cfg, input logic [WORD_W-1:0] ctr);
        t_ks_block w;
        w[3:0]   = SIGMA;
        w[11:4]  = cfg.key;
        w[12]    = ctr;
        w[15:13] = cfg.nonce;
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                                input int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    assign init_cur  = make_init(i_cfg, r_ctr);
    assign last_step = (r_step == 2'd3) && r_diag && (r_dround == DR_W'(DROUNDS - 1));

    // Next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            BL_IDLE:  if (i_req.start) n_st = BL_ROUND;
            BL_ROUND: if (last_step) n_st = BL_FINAL;
            BL_FINAL: n_st = BL_IDLE;
            default:  n_st = BL_IDLE;
        endcase
    end

    // Phase controls
    always_comb begin
        ld_init  = 1'b0;
        do_round = 1'b0;
        do_final = 1'b0;
        case (r_st)
            BL_IDLE:  ld_init  = i_req.start;
            BL_ROUND: do_round = 1'b1;
            BL_FINAL: do_final = 1'b1;
            default:  ;
        endcase
    end

    // One quarter-round step on all four lanes; diagonal pass skews the columns
    always_comb begin
        logic [1:0]        cb, cc, cd, lane;
        logic [WORD_W-1:0] a, b, c, d;
        n_work = r_work;
        for (int i = 0; i < 4; i++) begin
            lane = 2'(i);
            cb   = lane + (r_diag ? 2'd1 : 2'd0);
            cc   = lane + (r_diag ? 2'd2 : 2'd0);
            cd   = lane + (r_diag ? 2'd3 : 2'd0);
            a    = r_work[{2'd0, lane}];
            b    = r_work[{2'd1, cb}];
            c    = r_work[{2'd2, cc}];
            d    = r_work[{2'd3, cd}];
            case (r_step)
                2'd0: begin
                    a = a + b;
                    d = rotl(d ^ a, 16);
                end
                2'd1: begin
                    c = c + d;
                    b = rotl(b ^ c, 12);
                end
                2'd2: begin
                    a = a + b;
                    d = rotl(d ^ a, 8);
                end
                2'd3: begin
                    c = c + d;
                    b = rotl(b ^ c, 7);
                end
                default: ;
            endcase
            n_work[{2'd0, lane}] = a;
            n_work[{2'd1, cb}]   = b;
            n_work[{2'd2, cc}]   = c;
            n_work[{2'd3, cd}]   = d;
        end
    end

    // Feed-forward addition
    always_comb begin
        for (int i = 0; i < STATE_WORDS; i++) begin
            ff_sum[i] = r_work[i] + init_cur[i];
        end
    end

    // Working state and keystream block
    always_ff @(posedge i_clk) begin
        if (ld_init) begin
            r_work <= make_init(i_cfg, i_req.ctr);
            r_ctr  <= i_req.ctr;
        end else if (do_round) begin
            r_work <= n_work;
        end
        if (do_final) begin
            r_ks <= ff_sum;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= BL_IDLE;
            r_step   <= '0;
            r_diag   <= 1'b0;
            r_dround <= '0;
            r_done   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= do_final;
            if (ld_init) begin
                r_step   <= '0;
                r_diag   <= 1'b0;
                r_dround <= '0;
            end else if (do_round) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_diag <= ~r_diag;
                    if (r_diag) begin
                        r_dround <= r_dround + DR_W'(1);
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_ks   = r_ks;

endmodule

>>> design/chacha_back.sv
module chacha_back import chacha_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  logic      i_job_valid,
    output logic      o_pop,
    output t_blk_req  o_blk_req,
    input  logic      i_blk_done,
    input  t_ks_block i_ks,
    chacha_out_if.source o_result
);

    t_back_st          r_st, n_st;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              out_free, load;
    logic [WORD_W-1:0] ks_word;
    logic [BYTE_W-1:0] ks_byte;

    assign out_free = !r_out_valid || o_result.ready;

    // Keystream byte, least significant first within a word
    assign ks_word = i_ks[i_job.pos[POS_W-1:2]];
    assign ks_byte = ks_word[{i_job.pos[1:0], 3'b000} +: BYTE_W];

    // Next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            BK_IDLE: if (i_job_valid && i_job.new_blk) n_st = BK_GEN;
            BK_GEN:  if (i_blk_done) n_st = BK_EMIT;
            BK_EMIT: if (out_free) n_st = BK_IDLE;
            default: n_st = BK_IDLE;
        endcase
    end

    // Block requests and result loads
    always_comb begin
        o_blk_req.start = 1'b0;
        o_blk_req.ctr   = i_job.ctr;
        load            = 1'b0;
        case (r_st)
            BK_IDLE: begin
                o_blk_req.start = i_job_valid && i_job.new_blk;
                load            = i_job_valid && !i_job.new_blk && out_free;
            end
            BK_GEN:  ;
            BK_EMIT: load = out_free;
            default: ;
        endcase
    end

    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= i_job.data ^ ks_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.result_byte = r_out_byte;

endmodule

>>> design/chacha20_stream_cipher.sv
// A byte inside a block passes the queue and is then registered as the result byte. The
// first byte of a block waits for request, round steps (one per quarter-round step on
// four lanes), feed-forward, done handover and emit. Throughput: one byte per cycle
// within a block while output is ready; a new 64-byte block waits for its keystream.
// Reset (synchronous, active low) clears configuration, counter, byte position and queue.
module chacha20_stream_cipher import chacha_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    chacha_in_if.sink     i_data,
    chacha_out_if.source  o_result,
    chacha_cfg_if.sink    i_cfg
);

    t_cfg      r_cfg, n_cfg;
    t_job      front_job, head_job;
    logic      push, full, head_valid, pop;
    t_blk_req  blk_req;
    logic      blk_done;
    t_ks_block ks;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_KEY01:    n_cfg.key[1:0]  = i_cfg.data;
                CFG_KEY23:    n_cfg.key[3:2]  = i_cfg.data;
                CFG_KEY45:    n_cfg.key[5:4]  = i_cfg.data;
                CFG_KEY67:    n_cfg.key[7:6]  = i_cfg.data;
                CFG_NONCE01:  n_cfg.nonce[1:0] = i_cfg.data;
                CFG_NONCE2:   n_cfg.nonce[2]  = i_cfg.data[WORD_W-1:0];
                CFG_INIT_CTR: n_cfg.init_ctr  = i_cfg.data[WORD_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    chacha_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data     (i_data),
        .i_init_ctr (r_cfg.init_ctr),
        .i_full     (full),
        .o_push     (push),
        .o_job      (front_job)
    );

    chacha_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_job),
        .o_full  (full),
        .o_valid (head_valid),
        .i_pop   (pop),
        .o_rdata (head_job)
    );

    chacha_block u_block (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (blk_req),
        .i_cfg   (r_cfg),
        .o_done  (blk_done),
        .o_ks    (ks)
    );

    chacha_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_valid (head_valid),
        .o_pop       (pop),
        .o_blk_req   (blk_req),
        .i_blk_done  (blk_done),
        .i_ks        (ks),
        .o_result    (o_result)
    );

    // A block is only requested for a queued word that opens a block
    a_start_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blk_req.start |-> (head_valid && head_job.new_blk))
        else $error("block request without a block-opening word at the queue head");

    // Nothing leaves an empty queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

    // A request is a single pulse, and a block never finishes in the next cycle
    a_start_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blk_req.start |=> (!blk_req.start && !blk_done))
        else $error("block request repeated or completed too early");

    // Completion is a single pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blk_done |=> !blk_done)
        else $error("block completion held for more than one cycle");

endmodule
